// ----- design/km2d_pkg.sv -----
// km2d_pkg: types and constants shared by the 2D k-means block.
// No dependencies.
package km2d_pkg;
	// cluster_index width ties the cluster count to eight
	localparam int MAX_CLUSTERS = 8;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_LIMIT     = 2'd1;
	localparam logic [1:0] ST_FEW       = 2'd2;
	localparam logic [1:0] ST_DROPPED   = 2'd3;

	localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
	localparam logic [1:0] REG_TOL_SQUARED  = 2'd1;
	localparam logic [1:0] REG_MAX_ITER     = 2'd2;

	// request/response between the sequencer and the divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ----- design/km2d_div.sv -----
// km2d_div: signed restoring divider, one quotient bit per cycle,
// truncating toward zero. Depends on km2d_pkg.
module km2d_div import km2d_pkg::*; #(
	parameter int NUM_BITS = 26,
	parameter int DEN_BITS = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic        [DEN_BITS-1:0] den,
	output logic signed [NUM_BITS-1:0] quo,
	output div_ctl_t                   ctl
);
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] mag_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic                neg_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q, done_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   shifted;

	assign shifted = {rem_q[DEN_BITS-1:0], mag_q[NUM_BITS-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
			neg_q <= num[NUM_BITS-1];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DEN_BITS]) begin
				rem_q <= trial;
				mag_q <= {mag_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(mag_q) : $signed(mag_q);
	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule

// ----- design/kmeans_2d_clustering.sv -----
// Lloyd k-means over up to MAX_POINTS stored 2D points. Points are taken one per
// cycle until the item marked last_point; the block then runs passes (none when fewer
// points than clusters arrived) and is not ready until every result is delivered.
// Each pass runs the assignment (one point-memory read, then one centroid distance
// at a time through a single shared multiplier, squaring dx then dy, then one
// accumulate), the update through the shared serial divider per non-empty cluster,
// and the convergence check. Results then leave one per cycle as taken.
// No clearing pass is needed after reset.
module kmeans_2d_clustering import km2d_pkg::*; #(
	parameter int MAX_POINTS   = 1024,
	parameter int COORD_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [32:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                  last_point,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [2:0]            cluster_index,
	output logic signed [COORD_BITS-1:0] centroid_x,
	output logic signed [COORD_BITS-1:0] centroid_y,
	output logic [15:0]           passes_used,
	output logic                  last_result
);
	localparam int PW   = $clog2(MAX_POINTS);
	localparam int NW   = PW + 1;
	localparam int KW   = $clog2(MAX_CLUSTERS);
	localparam int KCW  = KW + 1;
	localparam int SUMW = COORD_BITS + PW + 1;
	localparam int DW   = COORD_BITS + 1;
	localparam int SQW  = 2 * DW + 1;

	typedef enum logic [8:0] {
		S_LOAD  = 9'b000000001,
		S_INIT  = 9'b000000010,
		S_CLR   = 9'b000000100,
		S_RD    = 9'b000001000,
		S_DIST  = 9'b000010000,
		S_ACC   = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_CHK   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [3:0]  num_clusters_q;
	logic [32:0] tol_q;
	logic [15:0] max_iter_q;

	logic [2*COORD_BITS-1:0] pmem [MAX_POINTS];
	logic [2*COORD_BITS-1:0] prd_q;
	logic [NW-1:0] count_q;
	logic          ovf_q;

	logic signed [COORD_BITS-1:0] cx_q [MAX_CLUSTERS];
	logic signed [COORD_BITS-1:0] cy_q [MAX_CLUSTERS];
	logic signed [COORD_BITS-1:0] nx_q [MAX_CLUSTERS];
	logic signed [COORD_BITS-1:0] ny_q [MAX_CLUSTERS];
	logic signed [SUMW-1:0] sx_q [MAX_CLUSTERS];
	logic signed [SUMW-1:0] sy_q [MAX_CLUSTERS];
	logic [NW-1:0] mc_q [MAX_CLUSTERS];

	logic [15:0]   pass_q;
	logic [15:0]   lim_q;
	logic [KCW-1:0] k_q;
	logic [NW-1:0] p_q;
	logic [KW-1:0] c_q;
	logic          half_q;   // 0: dx*dx, 1: dy*dy
	logic          dsel_q;   // divider on x (0) or y (1)
	logic          dstart_q;
	logic          settled_q;
	logic [SQW-1:0] dacc_q, best_d_q;
	logic [KW-1:0]  best_q;
	logic [1:0]     st_q;
	logic           few_q;

	// shared multiplier: one signed square per cycle
	logic signed [DW-1:0] mul_a;
	logic signed [2*DW-1:0] prod;
	logic [2*DW-1:0]      sq;
	logic signed [COORD_BITS-1:0] px, py, ax, ay, bx, by;
	logic [SQW-1:0] dist_sum;
	logic           chk_ok;

	assign px = prd_q[2*COORD_BITS-1:COORD_BITS];
	assign py = prd_q[COORD_BITS-1:0];

	always_comb begin
		if (state_q == S_CHK) begin
			ax = nx_q[c_q]; ay = ny_q[c_q];
		end else begin
			ax = px; ay = py;
		end
		bx = cx_q[c_q];
		by = cy_q[c_q];
		mul_a = half_q ? (DW'(ay) - DW'(by)) : (DW'(ax) - DW'(bx));
		prod = mul_a * mul_a;
		sq = $unsigned(prod);
	end
	assign dist_sum = dacc_q + SQW'(sq);
	assign chk_ok   = settled_q && (dist_sum <= SQW'(tol_q));

	// divider
	logic signed [SUMW-1:0] quo;
	div_ctl_t dctl;
	km2d_div #(.NUM_BITS(SUMW), .DEN_BITS(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q),
		.num(dsel_q ? sy_q[c_q] : sx_q[c_q]), .den(mc_q[c_q]),
		.quo(quo), .ctl(dctl)
	);

	assign cfg_ready = (state_q == S_LOAD);
	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign status        = few_q ? ST_FEW : st_q;
	assign cluster_index = few_q ? 3'd0 : 3'(c_q);
	assign centroid_x    = few_q ? '0 : cx_q[c_q];
	assign centroid_y    = few_q ? '0 : cy_q[c_q];
	assign passes_used   = few_q ? '0 : pass_q;
	assign last_result   = few_q || (KCW'(c_q) + 1'b1 == k_q);

	logic [KCW-1:0] k_eff;
	always_comb begin
		if (num_clusters_q == 4'd0) k_eff = KCW'(1);
		else if (32'(num_clusters_q) > MAX_CLUSTERS) k_eff = KCW'(MAX_CLUSTERS);
		else k_eff = KCW'(num_clusters_q);
	end

	logic in_acc;
	assign in_acc = in_valid && in_ready;
	logic [NW-1:0] n_after;
	assign n_after = (count_q < NW'(MAX_POINTS)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk) begin
		if (in_acc && count_q < NW'(MAX_POINTS))
			pmem[count_q[PW-1:0]] <= {point_x, point_y};
		prd_q <= pmem[p_q[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			num_clusters_q <= 4'd3;
			tol_q <= '0;
			max_iter_q <= 16'd1000;
			count_q <= '0;
			ovf_q <= 1'b0;
			pass_q <= '0;
			p_q <= '0;
			c_q <= '0;
			half_q <= 1'b0;
			dsel_q <= 1'b0;
			dstart_q <= 1'b0;
			few_q <= 1'b0;
			k_q <= KCW'(1);
			lim_q <= 16'd1;
			st_q <= ST_CONVERGED;
			settled_q <= 1'b0;
			dacc_q <= '0;
			best_d_q <= '0;
			best_q <= '0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				sx_q[i] <= '0; sy_q[i] <= '0; mc_q[i] <= '0;
				cx_q[i] <= '0; cy_q[i] <= '0; nx_q[i] <= '0; ny_q[i] <= '0;
			end
		end else begin
			dstart_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_NUM_CLUSTERS: num_clusters_q <= cfg_data[3:0];
							REG_TOL_SQUARED:  tol_q <= cfg_data;
							REG_MAX_ITER:     max_iter_q <= cfg_data[15:0];
							default: ;
						endcase
					end
					if (in_acc) begin
						count_q <= n_after;
						if (count_q >= NW'(MAX_POINTS)) ovf_q <= 1'b1;
						if (last_point) begin
							k_q <= k_eff;
							lim_q <= (max_iter_q == 16'd0) ? 16'd1 : max_iter_q;
							pass_q <= '0;
							c_q <= '0;
							p_q <= '0;
							if (count_q >= NW'(MAX_POINTS)) st_q <= ST_DROPPED;
							else st_q <= ovf_q ? ST_DROPPED : ST_CONVERGED;
							if (n_after < NW'(k_eff)) begin
								few_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								few_q <= 1'b0;
								state_q <= S_INIT;
							end
						end
					end
				end
				S_INIT: begin
					// prd_q holds point c_q in the cycle after p_q = c_q
					if (half_q) begin
						cx_q[c_q] <= px;
						cy_q[c_q] <= py;
						half_q <= 1'b0;
						if (KCW'(c_q) + 1'b1 == k_q) begin
							c_q <= '0;
							state_q <= S_CLR;
						end else begin
							c_q <= c_q + 1'b1;
							p_q <= p_q + 1'b1;
						end
					end else begin
						half_q <= 1'b1;
					end
				end
				S_CLR: begin
					for (int i = 0; i < MAX_CLUSTERS; i++) begin
						sx_q[i] <= '0; sy_q[i] <= '0; mc_q[i] <= '0;
					end
					p_q <= '0;
					c_q <= '0;
					half_q <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: begin
					dacc_q <= '0;
					state_q <= S_DIST;
				end
				S_DIST: begin
					if (!half_q) begin
						dacc_q <= SQW'(sq);
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						dacc_q <= '0;
						if (c_q == '0 || dist_sum < best_d_q) begin
							best_d_q <= dist_sum;
							best_q <= c_q;
						end
						if (KCW'(c_q) + 1'b1 == k_q) state_q <= S_ACC;
						else c_q <= c_q + 1'b1;
					end
				end
				S_ACC: begin
					sx_q[best_q] <= sx_q[best_q] + SUMW'(px);
					sy_q[best_q] <= sy_q[best_q] + SUMW'(py);
					mc_q[best_q] <= mc_q[best_q] + 1'b1;
					c_q <= '0;
					if (p_q + 1'b1 == count_q) begin
						pass_q <= pass_q + 1'b1;
						dsel_q <= 1'b0;
						state_q <= S_DIV;
					end else begin
						p_q <= p_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DIV: begin
					if (mc_q[c_q] == '0) begin
						nx_q[c_q] <= cx_q[c_q];
						ny_q[c_q] <= cy_q[c_q];
						if (KCW'(c_q) + 1'b1 == k_q) begin
							c_q <= '0; half_q <= 1'b0; dacc_q <= '0;
							settled_q <= 1'b1;
							state_q <= S_CHK;
						end else c_q <= c_q + 1'b1;
					end else if (!dctl.busy && !dctl.done && !dstart_q) begin
						dstart_q <= 1'b1;
					end else if (dctl.done) begin
						if (!dsel_q) begin
							nx_q[c_q] <= COORD_BITS'(quo);
							dsel_q <= 1'b1;
						end else begin
							ny_q[c_q] <= COORD_BITS'(quo);
							dsel_q <= 1'b0;
							if (KCW'(c_q) + 1'b1 == k_q) begin
								c_q <= '0; half_q <= 1'b0; dacc_q <= '0;
								settled_q <= 1'b1;
								state_q <= S_CHK;
							end else c_q <= c_q + 1'b1;
						end
					end
				end
				S_CHK: begin
					if (!half_q) begin
						dacc_q <= SQW'(sq);
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						dacc_q <= '0;
						settled_q <= chk_ok;
						if (KCW'(c_q) + 1'b1 == k_q) begin
							c_q <= '0;
							if (chk_ok) begin
								state_q <= S_OUT;
							end else begin
								for (int i = 0; i < MAX_CLUSTERS; i++) begin
									cx_q[i] <= nx_q[i]; cy_q[i] <= ny_q[i];
								end
								if (pass_q >= lim_q) begin
									if (st_q != ST_DROPPED) st_q <= ST_LIMIT;
									state_q <= S_OUT;
								end else state_q <= S_CLR;
							end
						end else c_q <= c_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_result) begin
							count_q <= '0;
							ovf_q <= 1'b0;
							few_q <= 1'b0;
							c_q <= '0;
							p_q <= '0;
							state_q <= S_LOAD;
						end else c_q <= c_q + 1'b1;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input and output both open");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !few_q |-> KCW'(c_q) < k_q) else $error("result index past k");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> p_q < count_q) else $error("point index past count");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(c_q))
		else $error("result dropped while stalled");
endmodule
